// ----- rtl/sai_pkg.sv -----
// ----------------------------------------------------------------------------
// sai_pkg
// Shared types and constants for the sign alternating interleaver.
// ----------------------------------------------------------------------------
package sai_pkg;

    localparam int WORD_W         = 32;
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        SEQ_LOAD,
        SEQ_START,
        SEQ_EMIT
    } seq_state_t;

    typedef struct packed {
        logic nonneg_we;
        logic neg_we;
        logic nonneg_re;
        logic neg_re;
    } buf_ctrl_t;

endpackage

// ----- rtl/sai_buffer.sv -----
// ----------------------------------------------------------------------------
// sai_buffer
// Single write port, single read port buffer with a registered read.
// ----------------------------------------------------------------------------
module sai_buffer #(
    parameter int DEPTH = sai_pkg::CAPACITY_DEF,
    parameter int WIDTH = sai_pkg::DATA_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sai_seq.sv -----
// ----------------------------------------------------------------------------
// sai_seq
// Load and emission sequencer: fill counts, read pointers and the shared
// selection unit that picks which buffer supplies the next word.
// ----------------------------------------------------------------------------
module sai_seq #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_last,
    input  logic               in_sign,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_last,
    output logic               dropped,
    output logic               sel_neg,
    output sai_pkg::buf_ctrl_t ctrl,
    output logic [ADDR_W-1:0]  waddr,
    output logic [ADDR_W-1:0]  raddr
);

    sai_pkg::seq_state_t state_reg, state_next;

    logic [CNT_W-1:0] nonneg_cnt_reg, nonneg_cnt_next;
    logic [CNT_W-1:0] neg_cnt_reg, neg_cnt_next;
    logic [CNT_W-1:0] nonneg_ptr_reg, nonneg_ptr_next;
    logic [CNT_W-1:0] neg_ptr_reg, neg_ptr_next;
    logic             overflow_reg, overflow_next;
    logic             want_nonneg_reg, want_nonneg_next;
    logic             sel_neg_reg, sel_neg_next;
    logic             last_reg, last_next;

    logic             in_accept;
    logic             out_accept;
    logic             issue;
    logic             full;
    logic             take_nonneg;
    logic [CNT_W:0]   total_sum;
    logic [CNT_W:0]   issued_sum;

    assign total_sum  = {1'b0, nonneg_cnt_reg} + {1'b0, neg_cnt_reg};
    assign issued_sum = {1'b0, nonneg_ptr_reg} + {1'b0, neg_ptr_reg} + (CNT_W + 1)'(1);
    assign full       = (total_sum == (CNT_W + 1)'(CAPACITY));
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid && out_ready;

    // The selection unit: the kind that is due, unless it has run out.
    assign take_nonneg = want_nonneg_reg ? (nonneg_ptr_reg < nonneg_cnt_reg)
                                         : (neg_ptr_reg >= neg_cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sai_pkg::SEQ_LOAD:
            begin
                if (in_accept && in_last)
                begin
                    state_next = sai_pkg::SEQ_START;
                end
            end
            sai_pkg::SEQ_START:
            begin
                state_next = sai_pkg::SEQ_EMIT;
            end
            sai_pkg::SEQ_EMIT:
            begin
                if (out_accept && last_reg)
                begin
                    state_next = sai_pkg::SEQ_LOAD;
                end
            end
            default:
            begin
                state_next = sai_pkg::SEQ_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        issue     = 1'b0;
        case (state_reg)
            sai_pkg::SEQ_LOAD:
            begin
                in_ready = 1'b1;
            end
            sai_pkg::SEQ_START:
            begin
                issue = 1'b1;
            end
            sai_pkg::SEQ_EMIT:
            begin
                out_valid = 1'b1;
                issue     = out_ready && !last_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        nonneg_cnt_next  = nonneg_cnt_reg;
        neg_cnt_next     = neg_cnt_reg;
        nonneg_ptr_next  = nonneg_ptr_reg;
        neg_ptr_next     = neg_ptr_reg;
        overflow_next    = overflow_reg;
        want_nonneg_next = want_nonneg_reg;
        sel_neg_next     = sel_neg_reg;
        last_next        = last_reg;
        ctrl             = '0;
        waddr            = in_sign ? neg_cnt_reg[ADDR_W-1:0] : nonneg_cnt_reg[ADDR_W-1:0];
        raddr            = take_nonneg ? nonneg_ptr_reg[ADDR_W-1:0]
                                       : neg_ptr_reg[ADDR_W-1:0];

        if (in_accept)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else if (in_sign)
            begin
                ctrl.neg_we  = 1'b1;
                neg_cnt_next = neg_cnt_reg + CNT_W'(1);
            end
            else
            begin
                ctrl.nonneg_we  = 1'b1;
                nonneg_cnt_next = nonneg_cnt_reg + CNT_W'(1);
            end
            if (in_last)
            begin
                nonneg_ptr_next  = '0;
                neg_ptr_next     = '0;
                want_nonneg_next = 1'b1;
            end
        end

        if (issue)
        begin
            ctrl.nonneg_re   = take_nonneg;
            ctrl.neg_re      = !take_nonneg;
            sel_neg_next     = !take_nonneg;
            want_nonneg_next = !want_nonneg_reg;
            last_next        = (issued_sum == total_sum);
            if (take_nonneg)
            begin
                nonneg_ptr_next = nonneg_ptr_reg + CNT_W'(1);
            end
            else
            begin
                neg_ptr_next = neg_ptr_reg + CNT_W'(1);
            end
        end

        if (out_accept && last_reg)
        begin
            nonneg_cnt_next = '0;
            neg_cnt_next    = '0;
            overflow_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sai_pkg::SEQ_LOAD;
            nonneg_cnt_reg  <= '0;
            neg_cnt_reg     <= '0;
            nonneg_ptr_reg  <= '0;
            neg_ptr_reg     <= '0;
            overflow_reg    <= 1'b0;
            want_nonneg_reg <= 1'b1;
            sel_neg_reg     <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            nonneg_cnt_reg  <= nonneg_cnt_next;
            neg_cnt_reg     <= neg_cnt_next;
            nonneg_ptr_reg  <= nonneg_ptr_next;
            neg_ptr_reg     <= neg_ptr_next;
            overflow_reg    <= overflow_next;
            want_nonneg_reg <= want_nonneg_next;
            sel_neg_reg     <= sel_neg_next;
            last_reg        <= last_next;
        end
    end

    assign out_last = last_reg;
    assign dropped  = overflow_reg;
    assign sel_neg  = sel_neg_reg;

endmodule

// ----- rtl/sign_alternating_interleaver.sv -----
// ----------------------------------------------------------------------------
// sign_alternating_interleaver
// Loads a set of signed words one word per cycle, sorting them by sign into
// two order-keeping buffers that hold up to CAPACITY words in total. The
// word marked last_item closes the set; the block then stops taking words,
// primes the buffer read in its start state and sends one word per cycle
// while the receiver is ready, the pace being set by the single read
// address shared by both buffers. Output alternates starting with a
// non-negative word; when one kind runs out the rest of the other follows
// in arrival order. Words beyond capacity are dropped and every word of
// that set carries the dropped flag.
// ----------------------------------------------------------------------------
module sign_alternating_interleaver #(
    parameter int CAPACITY   = sai_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = sai_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [sai_pkg::WORD_W-1:0] value,
    input  logic                       last_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sai_pkg::WORD_W-1:0] out_value,
    output logic                       out_last,
    output logic                       dropped
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int EXT_W  = sai_pkg::WORD_W + DATA_WIDTH;

    sai_pkg::buf_ctrl_t ctrl;

    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic                  sel_neg;
    logic [EXT_W-1:0]      in_ext;
    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] nonneg_rdata;
    logic [DATA_WIDTH-1:0] neg_rdata;
    logic [DATA_WIDTH-1:0] out_word;
    logic [EXT_W-1:0]      out_ext;

    assign in_ext = {{DATA_WIDTH{1'b0}}, value};
    assign word   = in_ext[DATA_WIDTH-1:0];

    sai_seq #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_last   (last_item),
        .in_sign   (word[DATA_WIDTH-1]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (out_last),
        .dropped   (dropped),
        .sel_neg   (sel_neg),
        .ctrl      (ctrl),
        .waddr     (waddr),
        .raddr     (raddr)
    );

    sai_buffer #(
        .DEPTH  (CAPACITY),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_nonneg_buf (
        .clk   (clk),
        .we    (ctrl.nonneg_we),
        .waddr (waddr),
        .wdata (word),
        .re    (ctrl.nonneg_re),
        .raddr (raddr),
        .rdata (nonneg_rdata)
    );

    sai_buffer #(
        .DEPTH  (CAPACITY),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_neg_buf (
        .clk   (clk),
        .we    (ctrl.neg_we),
        .waddr (waddr),
        .wdata (word),
        .re    (ctrl.neg_re),
        .raddr (raddr),
        .rdata (neg_rdata)
    );

    assign out_word  = sel_neg ? neg_rdata : nonneg_rdata;
    assign out_ext   = {{sai_pkg::WORD_W{out_word[DATA_WIDTH-1]}}, out_word};
    assign out_value = out_ext[sai_pkg::WORD_W-1:0];

endmodule

// ----- tb/sign_alternating_interleaver_tb.sv -----
// ----------------------------------------------------------------------------
// sign_alternating_interleaver_tb
// Feeds sets of signed words through the interleaver and checks every output
// word against a predictor that sorts each set by sign and interleaves it.
// The sender works in random bursts, the receiver stalls on changing patterns
// and once holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module sign_alternating_interleaver_tb;

    localparam int CAP = 64;
    localparam int DW  = 32;
    localparam logic [sai_pkg::WORD_W-1:0] DATA_MASK =
        (DW >= sai_pkg::WORD_W) ? '1 : ((1 << DW) - 1);

    typedef struct {
        logic [sai_pkg::WORD_W-1:0] word;
        logic                       last;
    } in_word_t;

    typedef struct {
        logic [sai_pkg::WORD_W-1:0] word;
        logic                       last;
        logic                       dropped;
    } arranged_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [sai_pkg::WORD_W-1:0] value     = '0;
    logic                       last_item = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [sai_pkg::WORD_W-1:0] out_value;
    logic                       out_last;
    logic                       dropped;

    in_word_t                   word_q[$];
    arranged_t                  arranged_q[$];
    logic [sai_pkg::WORD_W-1:0] nonneg_words[$];
    logic [sai_pkg::WORD_W-1:0] neg_words[$];
    bit                         overflow_seen;
    int                         mismatches;
    int                         words_taken;
    int                         burst_left;
    int                         gap_left;
    int                         stall_mode;
    int                         mode_left;
    int                         hold_left;
    bit                         hold_done;
    in_word_t                   next_word;
    arranged_t                  got;
    arranged_t                  want;

    sign_alternating_interleaver #(
        .CAPACITY   (CAP),
        .DATA_WIDTH (DW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .last_item (last_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_value (out_value),
        .out_last  (out_last),
        .dropped   (dropped)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [sai_pkg::WORD_W-1:0] sign_fill(
        input logic [sai_pkg::WORD_W-1:0] w);
        logic [sai_pkg::WORD_W-1:0] r;
        r = w & DATA_MASK;
        if (r[DW-1])
            r = r | ~DATA_MASK;
        return r;
    endfunction

    task automatic sort_and_interleave(input logic [sai_pkg::WORD_W-1:0] v,
                                       input logic lst);
        logic [sai_pkg::WORD_W-1:0] w;
        int                         total;
        int                         ip;
        int                         ineg;
        int                         k;
        bit                         want_nonneg;
        bit                         take_nonneg;
        arranged_t                  r;
        w = v & DATA_MASK;
        if (nonneg_words.size() + neg_words.size() >= CAP)
            overflow_seen = 1'b1;
        else if (w[DW-1])
            neg_words.insert(neg_words.size(), w);
        else
            nonneg_words.insert(nonneg_words.size(), w);
        if (lst)
        begin
            total = nonneg_words.size() + neg_words.size();
            ip = 0;
            ineg = 0;
            want_nonneg = 1'b1;
            for (k = 0; k < total; k++)
            begin
                take_nonneg = want_nonneg ? (ip < nonneg_words.size())
                                          : (ineg >= neg_words.size());
                if (take_nonneg)
                begin
                    r.word = sign_fill(nonneg_words[ip]);
                    ip++;
                end
                else
                begin
                    r.word = sign_fill(neg_words[ineg]);
                    ineg++;
                end
                want_nonneg = !want_nonneg;
                r.last = (k + 1 == total);
                r.dropped = overflow_seen;
                arranged_q.insert(arranged_q.size(), r);
            end
            nonneg_words.delete();
            neg_words.delete();
            overflow_seen = 1'b0;
        end
    endtask

    task automatic add_word(input logic [sai_pkg::WORD_W-1:0] v, input logic lst);
        in_word_t w;
        w.word = v;
        w.last = lst;
        word_q.insert(word_q.size(), w);
    endtask

    task automatic add_random_set(input int size);
        logic [sai_pkg::WORD_W-1:0] v;
        int                         i;
        int                         pick;
        for (i = 0; i < size; i++)
        begin
            pick = $urandom_range(0, 9);
            case (pick) inside
                [0:3]:   v = $urandom;
                [4:6]:   v = $urandom_range(0, 100);
                default: v = -$urandom_range(1, 100);
            endcase
            add_word(v, i == size - 1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value <= '0;
            last_item <= 1'b0;
            words_taken <= 0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                sort_and_interleave(value, last_item);
                words_taken <= words_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_q.size() > 0)
                begin
                    next_word = word_q.pop_front();
                    in_valid <= 1'b1;
                    value <= next_word.word;
                    last_item <= next_word.last;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (!hold_done && words_taken >= 100)
            begin
                hold_done = 1'b1;
                hold_left = 250;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= (mode_left % 3 == 0);
                    default: out_ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got.word = out_value;
            got.last = out_last;
            got.dropped = dropped;
            if (arranged_q.size() == 0)
            begin
                $error("unexpected output word %h", got.word);
                mismatches++;
            end
            else
            begin
                want = arranged_q.pop_front();
                if (got.word !== want.word)
                begin
                    $error("out_value: expected %h, got %h", want.word, got.word);
                    mismatches++;
                end
                if (got.last !== want.last)
                begin
                    $error("out_last: expected %b, got %b", want.last, got.last);
                    mismatches++;
                end
                if (got.dropped !== want.dropped)
                begin
                    $error("dropped: expected %b, got %b", want.dropped, got.dropped);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int s;
        add_word(32'h0000_0000, 1'b1);
        add_word(32'h8000_0000, 1'b1);
        add_word(32'h7FFF_FFFF, 1'b0);
        add_word(32'hFFFF_FFFF, 1'b0);
        add_word(32'h0000_0000, 1'b0);
        add_word(32'h8000_0000, 1'b1);
        add_word(-1, 1'b0);
        add_word(-2, 1'b0);
        add_word(-3, 1'b0);
        add_word(5, 1'b1);
        add_word(1, 1'b0);
        add_word(2, 1'b0);
        add_word(3, 1'b0);
        add_word(-7, 1'b1);
        add_word(-5, 1'b0);
        add_word(-6, 1'b1);
        add_word(9, 1'b0);
        add_word(10, 1'b0);
        add_word(11, 1'b1);
        add_word(32'hAAAA_AAAA, 1'b0);
        add_word(32'h5555_5555, 1'b1);
        s = 0;
        while (word_q.size() < 260)
        begin
            if (s % 12 == 2 && word_q.size() < 190)
                add_random_set($urandom_range(63, 70));
            else
                add_random_set($urandom_range(1, 12));
            s++;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (word_q.size() > 0 || in_valid || arranged_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && arranged_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
